/* design/lwcp_pkg.sv */
package lwcp_pkg;

	// fixed formats of the angle and trig paths
	localparam int ANGLE_BITS = 23;
	localparam int TRIG_BITS = 30;
	localparam int TRIG_W = TRIG_BITS + 1;
	localparam int CORDIC_W = 34;
	localparam int PI_W = 31;

	localparam logic [PI_W-1:0] PI_Q29 = 31'd1686629713;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam longint TRIG_ONE = 64'sd1 <<< TRIG_BITS;
	localparam int DEG_180 = 180;
	localparam int DEG_90 = 90;

	localparam logic [31:0] ATAN_Q30 [0:9] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
	};

	// arctangent of 2^-i in Q2.30
	function automatic logic signed [CORDIC_W-1:0] atan_step(input int unsigned i);
		logic signed [CORDIC_W-1:0] r;
		if (i < 10) begin
			r = $signed(CORDIC_W'(ATAN_Q30[i[3:0]]));
		end else if (i <= 30) begin
			r = (CORDIC_W'(1) <<< (30 - i)) - CORDIC_W'(1);
		end else begin
			r = '0;
		end
		return r;
	endfunction

endpackage

/* design/lwcp_div.sv */
module lwcp_div #(
	parameter int NB = 64,
	parameter int DB = 31,
	parameter int TB = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic signed [NB-1:0] num,
	input  logic [DB-1:0]        den,
	input  logic [TB-1:0]        tag,
	output logic                 out_valid,
	output logic signed [NB-1:0] quo,
	output logic [TB-1:0]        out_tag
);

	logic [DB-1:0] rem_s [0:NB];
	logic [NB-1:0] work_s [0:NB];
	logic [DB-1:0] den_s [0:NB];
	logic          neg_s [0:NB];
	logic [TB-1:0] tag_s [0:NB];
	logic          vld_s [0:NB];

	// magnitude and sign of the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= '0;
		work_s[0] <= num[NB-1] ? NB'(-num) : NB'(num);
		den_s[0] <= den;
		neg_s[0] <= num[NB-1];
		tag_s[0] <= tag;
	end

	// one restoring quotient bit per stage
	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic [DB:0] trial;
		logic        fits;
		assign trial = {rem_s[k], work_s[k][NB-1]};
		assign fits = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= fits ? DB'(trial - {1'b0, den_s[k]}) : DB'(trial);
			work_s[k+1] <= {work_s[k][NB-2:0], fits};
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	// restore the sign, truncating toward zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[NB];
		end
	end

	always_ff @(posedge clk) begin
		quo <= neg_s[NB] ? -$signed(work_s[NB]) : $signed(work_s[NB]);
		out_tag <= tag_s[NB];
	end

endmodule

/* design/lwcp_cordic.sv */
module lwcp_cordic #(
	parameter int STAGES = 24,
	parameter int TB = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [lwcp_pkg::CORDIC_W-1:0] z,
	input  logic [TB-1:0]                        tag,
	output logic                                 out_valid,
	output logic signed [lwcp_pkg::CORDIC_W-1:0] cx,
	output logic signed [lwcp_pkg::CORDIC_W-1:0] sy,
	output logic [TB-1:0]                        out_tag
);

	localparam int CW = lwcp_pkg::CORDIC_W;

	logic signed [CW-1:0] x_s [0:STAGES];
	logic signed [CW-1:0] y_s [0:STAGES];
	logic signed [CW-1:0] z_s [0:STAGES];
	logic [TB-1:0]        tag_s [0:STAGES];
	logic                 vld_s [0:STAGES];

	// start vector on the x axis, pre-scaled by the gain
	assign x_s[0] = lwcp_pkg::CORDIC_GAIN;
	assign y_s[0] = '0;
	assign z_s[0] = z;
	assign tag_s[0] = tag;
	assign vld_s[0] = in_valid;

	// rotation-mode micro-rotations, floor shifts
	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [CW-1:0] ATAN = lwcp_pkg::atan_step(i);
		logic signed [CW-1:0] dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!z_s[i][CW-1]) begin
				x_s[i+1] <= x_s[i] - dx;
				y_s[i+1] <= y_s[i] + dy;
				z_s[i+1] <= z_s[i] - ATAN;
			end else begin
				x_s[i+1] <= x_s[i] + dx;
				y_s[i+1] <= y_s[i] - dy;
				z_s[i+1] <= z_s[i] + ATAN;
			end
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = vld_s[STAGES];
	assign cx = x_s[STAGES];
	assign sy = y_s[STAGES];
	assign out_tag = tag_s[STAGES];

endmodule

/* design/line_window_corner_projection.sv */
// Projects a window corner onto a line given by angle (degrees, Q7.16) and
// offset. A word is taken on every cycle that start is high (busy stays low),
// and its result appears on projection/saturated with a one-cycle done strobe,
// after the input register, the registered angle scaling, the unrolled CORDIC
// and the two bit-per-stage dividers (line height, final quotient). The
// receiver cannot stall; every result must be taken.
module line_window_corner_projection #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16,
	parameter int CORDIC_STAGES = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [lwcp_pkg::ANGLE_BITS-1:0]       angle_deg,
	input  logic signed [WORD_BITS-1:0]           line_offset,
	input  logic signed [WORD_BITS-1:0]           corner_x,
	input  logic signed [WORD_BITS-1:0]           corner_y,
	output logic                                  done,
	output logic signed [WORD_BITS-1:0]           projection,
	output logic                                  saturated
);

	localparam int W = WORD_BITS;
	localparam int CW = lwcp_pkg::CORDIC_W;
	localparam int TW = lwcp_pkg::TRIG_W;
	localparam int TB = lwcp_pkg::TRIG_BITS;
	localparam int PB = lwcp_pkg::ANGLE_BITS + lwcp_pkg::PI_W;
	localparam int SB = W + 32;
	localparam int NB2 = W + TB;
	localparam logic signed [W-1:0] W_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};

	// in-range angles keep the scaled product below 2^39
	localparam int NZ = 39;
	// ceil(2^47 / 180), exact for dividends below 2^40
	localparam int RK = 47;
	localparam logic [39:0] RECIP_180 = 40'd781874935308;
	localparam logic [19:0] RC_HI = RECIP_180[39:20];
	localparam logic [19:0] RC_LO = RECIP_180[19:0];

	typedef struct packed {
		logic                zero;
		logic                ninety;
		logic signed [W-1:0] off;
		logic signed [W-1:0] x0;
		logic signed [W-1:0] y0;
	} item_t;

	typedef struct packed {
		item_t         item;
		logic [TW-1:0] c;
		logic [TW-1:0] s;
	} trig_t;

	typedef struct packed {
		item_t               item;
		logic                over;
		logic signed [W-1:0] n;
	} fin_t;

	function automatic logic [TW-1:0] clamp_trig(input logic signed [CW-1:0] v);
		logic [TW-1:0] r;
		if (v < 1) begin
			r = TW'(1);
		end else if (v > lwcp_pkg::TRIG_ONE) begin
			r = TW'(lwcp_pkg::TRIG_ONE);
		end else begin
			r = TW'(v);
		end
		return r;
	endfunction

	assign busy = 1'b0;

	// input word register, special angle flags
	logic                                 vld_s1;
	logic [lwcp_pkg::ANGLE_BITS-1:0]      ang_s1;
	item_t                                item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ang_s1 <= angle_deg;
		item_s1.zero <= angle_deg == '0;
		item_s1.ninety <= 64'(angle_deg) >= (64'(lwcp_pkg::DEG_90) << FRAC_BITS);
		item_s1.off <= line_offset;
		item_s1.x0 <= corner_x;
		item_s1.y0 <= corner_y;
	end

	// degrees times pi
	logic          vld_s2;
	logic [PB-1:0] prod_s2;
	item_t         item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PB'(ang_s1) * PB'(lwcp_pkg::PI_Q29);
		item_s2 <= item_s1;
	end

	// partial products of the scaled angle and 1/180
	logic [NZ-1:0] zn;
	logic          vld_s2b;
	logic [38:0]   hh_s2b, hl_s2b;
	logic [39:0]   lh_s2b, ll_s2b;
	item_t         item_s2b;

	assign zn = NZ'(prod_s2 >> (FRAC_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2b <= 1'b0;
		end else begin
			vld_s2b <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		hh_s2b <= 39'(zn[NZ-1:20]) * 39'(RC_HI);
		hl_s2b <= 39'(zn[NZ-1:20]) * 39'(RC_LO);
		lh_s2b <= 40'(zn[19:0]) * 40'(RC_HI);
		ll_s2b <= 40'(zn[19:0]) * 40'(RC_LO);
		item_s2b <= item_s2;
	end

	// radians in Q2.30 from the summed products
	logic [78:0]              zp;
	logic                     vld_z;
	logic [CW-1:0]            z_q;
	logic [$bits(item_t)-1:0] tag_z;

	assign zp = {hh_s2b, 40'b0} + {20'b0, hl_s2b, 20'b0} + {19'b0, lh_s2b, 20'b0} +
		{39'b0, ll_s2b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_z <= 1'b0;
		end else begin
			vld_z <= vld_s2b;
		end
	end

	always_ff @(posedge clk) begin
		z_q <= CW'(zp[78:RK]);
		tag_z <= item_s2b;
	end

	// sine and cosine
	logic                 vld_cr;
	logic signed [CW-1:0] cx_cr, sy_cr;
	logic [$bits(item_t)-1:0] tag_cr;

	lwcp_cordic #(.STAGES(CORDIC_STAGES), .TB($bits(item_t))) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_z),
		.z($signed(z_q)),
		.tag(tag_z),
		.out_valid(vld_cr),
		.cx(cx_cr),
		.sy(sy_cr),
		.out_tag(tag_cr)
	);

	// clamp trig values into [2^-30, 1]
	logic          vld_s3;
	logic [TW-1:0] c_s3, s_s3;
	item_t         item_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_cr;
		end
	end

	always_ff @(posedge clk) begin
		c_s3 <= clamp_trig(cx_cr);
		s_s3 <= clamp_trig(sy_cr);
		item_s3 <= item_t'(tag_cr);
	end

	// x*sin and y*cos
	logic                 vld_s4;
	logic signed [SB-1:0] xs_s4, yc_s4;
	logic [TW-1:0]        c_s4, s_s4;
	item_t                item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		xs_s4 <= SB'(item_s3.x0) * $signed(SB'(s_s3));
		yc_s4 <= SB'(item_s3.y0) * $signed(SB'(c_s3));
		c_s4 <= c_s3;
		s_s4 <= s_s3;
		item_s4 <= item_s3;
	end

	// dividends for line height and the first quotient
	logic                 vld_s5;
	logic signed [SB-1:0] nyl_s5, na_s5;
	trig_t                trig_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		nyl_s5 <= xs_s4 + (SB'(item_s4.off) <<< TB);
		na_s5 <= yc_s4 - (SB'(item_s4.off) <<< TB);
		trig_s5.item <= item_s4;
		trig_s5.c <= c_s4;
		trig_s5.s <= s_s4;
	end

	// both divide by cos, side by side
	logic                 vld_yl;
	logic signed [SB-1:0] yl_q, qa_q;
	logic [$bits(trig_t)-1:0] tag_yl;

	lwcp_div #(.NB(SB), .DB(TW), .TB($bits(trig_t))) u_div_yl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s5),
		.num(nyl_s5),
		.den(trig_s5.c),
		.tag(trig_s5),
		.out_valid(vld_yl),
		.quo(yl_q),
		.out_tag(tag_yl)
	);

	lwcp_div #(.NB(SB), .DB(TW), .TB(1)) u_div_a (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s5),
		.num(na_s5),
		.den(trig_s5.c),
		.tag(1'b0),
		.out_valid(),
		.quo(qa_q),
		.out_tag()
	);

	// pick the quotient by region and offset sign
	trig_t                trig_yl;
	logic                 above, off_neg;
	logic                 vld_s6;
	logic signed [SB-1:0] num_s6;
	logic [TW-1:0]        d_s6;
	item_t                item_s6;

	assign trig_yl = trig_t'(tag_yl);
	assign above = SB'(trig_yl.item.y0) >= yl_q;
	assign off_neg = trig_yl.item.off[W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_yl;
		end
	end

	always_ff @(posedge clk) begin
		item_s6 <= trig_yl.item;
		if (above && !off_neg) begin
			num_s6 <= qa_q;
			d_s6 <= trig_yl.s;
		end else if (above) begin
			num_s6 <= SB'(trig_yl.item.y0);
			d_s6 <= trig_yl.s;
		end else if (!off_neg) begin
			num_s6 <= SB'(trig_yl.item.x0);
			d_s6 <= trig_yl.c;
		end else begin
			num_s6 <= yl_q;
			d_s6 <= trig_yl.s;
		end
	end

	// clamp the dividend to word range
	logic                vld_s7;
	fin_t                fin_s7;
	logic [TW-1:0]       d_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		fin_s7.item <= item_s6;
		d_s7 <= d_s6;
		if (num_s6 > SB'(W_MAX)) begin
			fin_s7.n <= W_MAX;
			fin_s7.over <= 1'b1;
		end else if (num_s6 < SB'(W_MIN)) begin
			fin_s7.n <= W_MIN;
			fin_s7.over <= 1'b1;
		end else begin
			fin_s7.n <= W'(num_s6);
			fin_s7.over <= 1'b0;
		end
	end

	// final quotient n * 2^30 / d
	logic                  vld_f;
	logic signed [NB2-1:0] qf_q;
	logic [$bits(fin_t)-1:0] tag_f;
	fin_t                  fin_f;

	lwcp_div #(.NB(NB2), .DB(TW), .TB($bits(fin_t))) u_div_fin (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s7),
		.num(NB2'(fin_s7.n) <<< TB),
		.den(d_s7),
		.tag(fin_s7),
		.out_valid(vld_f),
		.quo(qf_q),
		.out_tag(tag_f)
	);

	assign fin_f = fin_t'(tag_f);

	// output word with saturation and special angles
	logic                done_q;
	logic signed [W-1:0] proj_q;
	logic                sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			done_q <= vld_f;
			sat_q <= vld_f && !fin_f.item.zero && !fin_f.item.ninety &&
				(fin_f.over || qf_q > NB2'(W_MAX) || qf_q < NB2'(W_MIN));
		end
	end

	always_ff @(posedge clk) begin
		if (fin_f.item.zero) begin
			proj_q <= fin_f.item.x0;
		end else if (fin_f.item.ninety) begin
			proj_q <= fin_f.item.y0;
		end else if (fin_f.over) begin
			proj_q <= fin_f.n;
		end else if (qf_q > NB2'(W_MAX)) begin
			proj_q <= W_MAX;
		end else if (qf_q < NB2'(W_MIN)) begin
			proj_q <= W_MIN;
		end else begin
			proj_q <= W'(qf_q);
		end
	end

	assign done = done_q;
	assign projection = proj_q;
	assign saturated = sat_q;

	// a flagged result only comes with its strobe
	a_sat_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		saturated |-> done)
		else $error("saturated flag without a result");

	// a clamped result sits at one end of the range
	a_sat_end: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (projection == W_MAX || projection == W_MIN))
		else $error("saturated result not at range end");

endmodule
